// ----- hdl/tgc_pkg.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier package
// Shared types, codes and constants for the classifier block.
// ---------------------------------------------------------------------------
package tgc_pkg;

  localparam int unsigned GESTURE_LIMIT_MS_DEF = 2000;
  localparam int unsigned FLING_SPAN_MS_DEF    = 300;
  localparam int unsigned FLING_MAX_DT         = 100;
  localparam int unsigned ADDR_W               = 5;
  localparam int unsigned DIV_W                = 7;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PENDING  = 2'd1,
    PH_DRAG     = 2'd2,
    PH_CONSUMED = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ACT_FORWARD     = 3'd0,
    ACT_TAP         = 3'd1,
    ACT_BACK        = 3'd2,
    ACT_SCROLL_SET  = 3'd3,
    ACT_SCROLL_ANIM = 3'd4,
    ACT_LONG        = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    MODE_DOWN = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_UP   = 2'd2,
    MODE_TICK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DOWN = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_UP   = 2'd2
  } kind_t;

  typedef enum logic [ADDR_W-3:0] {
    REG_FORWARD_MOVES = 3'd0,
    REG_LP_ENABLE     = 3'd1,
    REG_MIN_OFFSET    = 3'd2,
    REG_TAP_SLOP      = 3'd3,
    REG_SWIPE_MIN     = 3'd4,
    REG_DRAG_START    = 3'd5,
    REG_LP_MS         = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FLING,
    ST_OUT0,
    ST_OUT1
  } state_t;

  // Input item.
  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         x_pos;
    logic [9:0]         y_pos;
    logic [31:0]        now_time;
    logic               unarmed_touch;
    logic               menu_on_top;
    logic               scrollable;
    logic signed [15:0] current_offset;
    logic               link_up;
    logic               same_layer;
  } item_in_t;

  // Result item.
  typedef struct packed {
    logic [2:0]         action;
    logic [1:0]         event_kind;
    logic [9:0]         x_out;
    logic [9:0]         y_out;
    logic signed [15:0] offset_out;
    logic               last;
  } item_out_t;

  // Configuration register file.
  typedef struct packed {
    logic               forward_moves;
    logic               long_press_enable;
    logic signed [15:0] min_scroll_offset;
    logic [7:0]         touch_slop;
    logic [9:0]         swipe_travel;
    logic [7:0]         drag_travel;
    logic [15:0]        hold_time;
  } cfg_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic div_step;
    logic fling;
    logic sel1;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic two;
    logic none;
  } stat_t;

endpackage

// ----- hdl/tgc_stream_if.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier stream interface
// Valid/ready channel carrying one payload of a chosen type.
// ---------------------------------------------------------------------------
interface tgc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/tgc_regs.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier register file
// APB-style configuration registers with read back.
// ---------------------------------------------------------------------------
module tgc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tgc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tgc_pkg::cfg_t              cfg
);
  import tgc_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_moves     <= 1'b0;
      cfg.long_press_enable <= 1'b1;
      cfg.min_scroll_offset <= 16'sd0;
      cfg.touch_slop        <= 8'd10;
      cfg.swipe_travel      <= 10'd30;
      cfg.drag_travel       <= 8'd8;
      cfg.hold_time         <= 16'd500;
    end else if (wr) begin
      case (idx)
        REG_FORWARD_MOVES: cfg.forward_moves     <= pwdata[0];
        REG_LP_ENABLE:     cfg.long_press_enable <= pwdata[0];
        REG_MIN_OFFSET:    cfg.min_scroll_offset <= pwdata[15:0];
        REG_TAP_SLOP:      cfg.touch_slop        <= pwdata[7:0];
        REG_SWIPE_MIN:     cfg.swipe_travel      <= pwdata[9:0];
        REG_DRAG_START:    cfg.drag_travel       <= pwdata[7:0];
        REG_LP_MS:         cfg.hold_time         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_FORWARD_MOVES: prdata = {31'd0, cfg.forward_moves};
      REG_LP_ENABLE:     prdata = {31'd0, cfg.long_press_enable};
      REG_MIN_OFFSET:    prdata = {{16{cfg.min_scroll_offset[15]}}, cfg.min_scroll_offset};
      REG_TAP_SLOP:      prdata = {24'd0, cfg.touch_slop};
      REG_SWIPE_MIN:     prdata = {22'd0, cfg.swipe_travel};
      REG_DRAG_START:    prdata = {24'd0, cfg.drag_travel};
      REG_LP_MS:         prdata = {16'd0, cfg.hold_time};
      default:           prdata = 32'd0;
    endcase
  end
endmodule

// ----- hdl/tgc_ctrl.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier controller
// Sequences evaluation, the fling divider and result delivery.
// ---------------------------------------------------------------------------
module tgc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tgc_pkg::stat_t  stat,
  output tgc_pkg::cmd_t   cmd
);
  import tgc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state. The result registers are settled in ST_OUT0, so an event
  // without any result is dropped there.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_EVAL;
      ST_EVAL: begin
        if (stat.need_div) state_next = ST_DIV;
        else               state_next = ST_OUT0;
      end
      ST_DIV:   if (stat.div_done) state_next = ST_FLING;
      ST_FLING: state_next = ST_OUT0;
      ST_OUT0: begin
        if (stat.none)     state_next = ST_IDLE;
        else if (out_ready) state_next = stat.two ? ST_OUT1 : ST_IDLE;
      end
      ST_OUT1:  if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EVAL: begin
        cmd.eval      = 1'b1;
        cmd.div_start = stat.need_div;
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FLING: cmd.fling = 1'b1;
      ST_OUT0:  out_valid = !stat.none;
      ST_OUT1: begin
        out_valid = 1'b1;
        cmd.sel1  = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ----- hdl/tgc_datapath.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier datapath
// Gesture state, classification logic, fling divider and result registers.
// ---------------------------------------------------------------------------
module tgc_datapath #(
  parameter int unsigned GESTURE_LIMIT_MS = tgc_pkg::GESTURE_LIMIT_MS_DEF,
  parameter int unsigned FLING_SPAN_MS    = tgc_pkg::FLING_SPAN_MS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tgc_pkg::item_in_t   in_data,
  input  tgc_pkg::cfg_t       cfg,
  input  tgc_pkg::cmd_t       cmd,
  output tgc_pkg::stat_t      stat,
  output tgc_pkg::item_out_t  out_data
);
  import tgc_pkg::*;

  // Dividend width: |dy| * span fits in 10 + $clog2(span + 1) bits.
  localparam int unsigned NUM_W = 10 + $clog2(FLING_SPAN_MS + 1);

  item_in_t           it;
  phase_t             phase;
  logic [9:0]         down_x, down_y, last_y, prev_y;
  logic [31:0]        down_time, last_time, prev_time;
  logic signed [15:0] down_offset, scroll_now;
  logic               hold_armed, has_scroller;
  item_out_t          res0, res1;
  logic               two, none;

  // Divider registers.
  logic [NUM_W-1:0]   quo;
  logic [DIV_W:0]     rem;
  logic [DIV_W-1:0]   dvs;
  logic               neg;
  logic [$clog2(NUM_W+1)-1:0] cnt;
  logic [NUM_W-1:0]   prod;

  logic signed [16:0] min_lo;

  // Wide enough for an offset plus the largest fling carry.
  function automatic logic signed [15:0] clampv(input logic signed [20:0] v,
                                               input logic signed [16:0] lo);
    logic signed [20:0] r;
    begin
      r = v;
      if (r > 21'sd0) r = 21'sd0;
      if (r < 21'(lo)) r = 21'(lo);
      return r[15:0];
    end
  endfunction

  function automatic item_out_t mk(input action_t a, input kind_t k,
                                   input logic [9:0] x, input logic [9:0] y,
                                   input logic signed [15:0] o);
    item_out_t r;
    begin
      r.action = a; r.event_kind = k; r.x_out = x; r.y_out = y;
      r.offset_out = o; r.last = 1'b0;
      return r;
    end
  endfunction

  assign min_lo = (cfg.min_scroll_offset > 16'sd0) ? 17'sd0 : 17'(cfg.min_scroll_offset);

  // Combinational evaluation of one event.
  logic [10:0]        adx, ady;
  logic signed [10:0] dx, dy_d;
  logic [31:0]        dt, el;
  logic               fling_go;
  logic signed [15:0] drag_off;

  always_comb begin
    dx   = signed'({1'b0, it.x_pos}) - signed'({1'b0, down_x});
    dy_d = signed'({1'b0, it.y_pos}) - signed'({1'b0, down_y});
    adx  = dx[10] ? 11'(-dx) : 11'(dx);
    ady  = dy_d[10] ? 11'(-dy_d) : 11'(dy_d);
    dt   = last_time - prev_time;
    el   = it.now_time - down_time;
    fling_go = (phase == PH_DRAG) && it.same_layer && (dt != 32'd0) &&
               (dt <= 32'(FLING_MAX_DT));
    drag_off = clampv(21'(down_offset) + 21'(dy_d), min_lo);
  end

  logic signed [10:0] fdy;
  assign fdy = signed'({1'b0, last_y}) - signed'({1'b0, prev_y});

  // Signed carry from divider.
  logic signed [NUM_W:0] carry;
  assign carry = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  assign stat.need_div = cmd.eval && (it.mode == MODE_UP) && fling_go;
  assign stat.div_done = (cnt == '0);
  assign stat.two      = two;
  assign stat.none     = none;

  assign out_data = cmd.sel1 ? res1 : res0;

  always_ff @(posedge clk) begin
    if (cmd.load) it <= in_data;
  end

  // Fling divider: restoring, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg  <= fdy[10];
      prod <= NUM_W'((fdy[10] ? 11'(-fdy) : 11'(fdy)) * FLING_SPAN_MS);
      quo  <= '0;
      rem  <= '0;
      dvs  <= dt[DIV_W-1:0];
      cnt  <= ($clog2(NUM_W+1))'(NUM_W);
    end else if (cmd.div_step && cnt != '0) begin
      logic [DIV_W+1:0] t;
      t = {rem, prod[NUM_W-1]} - {2'b00, dvs};
      prod <= prod << 1;
      if (!t[DIV_W+1]) begin
        rem <= t[DIV_W:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-1:0], prod[NUM_W-1]};
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end

  // Gesture state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      down_x <= '0; down_y <= '0; down_time <= '0; down_offset <= '0;
      scroll_now <= '0; last_y <= '0; prev_y <= '0;
      last_time <= '0; prev_time <= '0; hold_armed <= 1'b0;
      has_scroller <= 1'b0; two <= 1'b0; none <= 1'b0;
    end else if (cmd.fling) begin
      item_out_t          rf;
      logic signed [15:0] fo;
      fo = clampv(21'(scroll_now) + 21'(carry), min_lo);
      rf = mk(ACT_SCROLL_ANIM, KIND_DOWN, 10'd0, 10'd0, fo);
      rf.last = 1'b1;
      if (carry != '0) begin
        scroll_now <= fo;
        res0 <= rf;
        none <= 1'b0;
      end else begin
        none <= 1'b1;
      end
      two <= 1'b0;
    end else if (cmd.eval) begin
      logic n0, n1;
      item_out_t r0, r1;
      phase_t ph_n;
      logic arm_n;
      n0 = 1'b0; n1 = 1'b0;
      ph_n = phase; arm_n = hold_armed;
      r0 = mk(ACT_FORWARD, KIND_DOWN, it.x_pos, it.y_pos, 16'sd0);
      r1 = mk(ACT_FORWARD, KIND_MOVE, it.x_pos, it.y_pos, 16'sd0);
      case (it.mode)
        MODE_DOWN: begin
          n0 = 1'b1;
          arm_n = 1'b0;
          if (it.unarmed_touch) begin
            ph_n = PH_IDLE;
          end else begin
            ph_n = PH_PENDING;
            down_x <= it.x_pos; down_y <= it.y_pos; down_time <= it.now_time;
            last_y <= it.y_pos; prev_y <= it.y_pos;
            last_time <= it.now_time; prev_time <= it.now_time;
            has_scroller <= it.scrollable;
            down_offset <= it.scrollable ? it.current_offset : 16'sd0;
            scroll_now  <= it.scrollable ? it.current_offset : 16'sd0;
            arm_n = cfg.long_press_enable && it.menu_on_top;
          end
        end
        MODE_MOVE: begin
          logic step;
          step = 1'b0;
          if (phase == PH_PENDING || phase == PH_DRAG) begin
            prev_y <= last_y; prev_time <= last_time;
            last_y <= it.y_pos; last_time <= it.now_time;
          end
          if (phase == PH_PENDING) begin
            if (adx >= 11'(cfg.touch_slop) || ady >= 11'(cfg.touch_slop))
              arm_n = 1'b0;
            if (has_scroller && ady >= 11'(cfg.drag_travel)) begin
              arm_n = 1'b0;
              ph_n = PH_DRAG;
              step = 1'b1;
            end
          end else if (phase == PH_DRAG) begin
            step = 1'b1;
          end
          if (step) begin
            if (!it.same_layer || !has_scroller) begin
              ph_n = PH_CONSUMED;
            end else begin
              scroll_now <= drag_off;
              n0 = 1'b1;
              r0 = mk(ACT_SCROLL_SET, KIND_DOWN, 10'd0, 10'd0, drag_off);
            end
          end
          if (cfg.forward_moves) begin
            if (n0) n1 = 1'b1;
            else begin
              n0 = 1'b1;
              r0 = r1;
            end
          end
        end
        MODE_UP: begin
          logic done;
          done = 1'b0;
          arm_n = 1'b0;
          ph_n = PH_IDLE;
          if (phase == PH_DRAG || phase == PH_CONSUMED) begin
            done = 1'b1;
          end else if (phase == PH_PENDING && el <= 32'(GESTURE_LIMIT_MS)) begin
            if (adx < 11'(cfg.touch_slop) && ady < 11'(cfg.touch_slop)) begin
              if (it.menu_on_top) begin
                n0 = 1'b1; done = 1'b1;
                r0 = mk(ACT_TAP, KIND_DOWN, it.x_pos, it.y_pos, 16'sd0);
              end
            end else if (adx >= 11'(cfg.swipe_travel) && adx > ady && !dx[10] &&
                         dx != 11'sd0 && it.link_up) begin
              n0 = 1'b1; done = 1'b1;
              r0 = mk(ACT_BACK, KIND_DOWN, 10'd0, 10'd0, 16'sd0);
            end
          end
          if (!done) begin
            n0 = 1'b1;
            r0 = mk(ACT_FORWARD, KIND_UP, it.x_pos, it.y_pos, 16'sd0);
          end
        end
        default: begin
          if (hold_armed && el >= 32'(cfg.hold_time)) begin
            arm_n = 1'b0;
            if (phase == PH_PENDING && it.menu_on_top) begin
              ph_n = PH_CONSUMED;
              n0 = 1'b1;
              r0 = mk(ACT_LONG, KIND_DOWN, down_x, down_y, 16'sd0);
            end
          end
        end
      endcase
      r0.last = !n1;
      r1.last = 1'b1;
      phase <= ph_n;
      hold_armed <= arm_n;
      res0 <= r0;
      res1 <= r1;
      two  <= n1;
      none <= !n0;
    end
  end
endmodule

// ----- hdl/touch_gesture_classifier_unit.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier unit
// Classifies touch events into taps, swipes, scrolls, flings, long presses,
// or forwards them.
// Sequence: an accepted event is evaluated into the result registers, which
// are then shown; a liftoff ending a fast drag first runs the fling divider
// and applies its carry. One event at a time: a new event is taken only once
// every result of the last one has been delivered, and output stalls hold it.
// Reset: synchronous; gesture state idle and registers at their defaults.
module touch_gesture_classifier_unit #(
  parameter int unsigned GESTURE_LIMIT_MS = tgc_pkg::GESTURE_LIMIT_MS_DEF,
  parameter int unsigned FLING_SPAN_MS    = tgc_pkg::FLING_SPAN_MS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  tgc_stream_if.sink                 in_ch,
  tgc_stream_if.source               out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tgc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tgc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  tgc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  tgc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat, .cmd
  );

  tgc_datapath #(
    .GESTURE_LIMIT_MS(GESTURE_LIMIT_MS),
    .FLING_SPAN_MS   (FLING_SPAN_MS)
  ) u_dp (
    .clk, .rst,
    .in_data (in_ch.data),
    .cfg, .cmd, .stat,
    .out_data(out_ch.data)
  );
endmodule

// ----- hdl/tgc_checker.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
module tgc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input tgc_pkg::item_out_t   out_data,
  input logic                 pready
);
  import tgc_pkg::*;

  // No new event is taken while a result is waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready with pending result");

  // A result is never shown the cycle right after acceptance.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // A non-final result is always followed by another.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last) |=> out_valid)
    else $error("lost second result");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");

  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind touch_gesture_classifier_unit tgc_checker u_chk (
  .clk, .rst,
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data),
  .pready
);

// ----- sim/tb_touch_gesture_classifier_unit.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier testbench
// Drives touch events into the classifier, predicts every result from a
// behavioral copy of the gesture logic, and checks results in order. The
// run covers several register settings, directed corner cases, random
// gesture sequences and idling on both sides of the stream.
// ---------------------------------------------------------------------------
module tb_touch_gesture_classifier_unit;
  import tgc_pkg::*;

  // Scoreboard: behavioral gesture model plus a queue of expected results.
  class gesture_scoreboard;
    item_out_t   pending_results[$];
    int          error_count;
    logic        fwd_moves, lp_en;
    logic signed [15:0] min_off;
    logic [7:0]  slop, drag_thr;
    logic [9:0]  swipe_thr;
    logic [15:0] hold_ms;
    phase_t      phase;
    logic [9:0]  dn_x, dn_y, y_last, y_prev;
    logic [31:0] dn_time, t_last, t_prev;
    int          dn_off, scroll_pos;
    logic        armed, scroller;

    function new();
      error_count = 0;
      fwd_moves = 0; lp_en = 1; min_off = 0; slop = 10; swipe_thr = 30;
      drag_thr = 8; hold_ms = 500;
      phase = PH_IDLE;
      dn_x = 0; dn_y = 0; y_last = 0; y_prev = 0;
      dn_time = 0; t_last = 0; t_prev = 0;
      dn_off = 0; scroll_pos = 0; armed = 0; scroller = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_FORWARD_MOVES: fwd_moves = v[0];
        REG_LP_ENABLE:     lp_en = v[0];
        REG_MIN_OFFSET:    min_off = v[15:0];
        REG_TAP_SLOP:      slop = v[7:0];
        REG_SWIPE_MIN:     swipe_thr = v[9:0];
        REG_DRAG_START:    drag_thr = v[7:0];
        REG_LP_MS:         hold_ms = v[15:0];
        default: ;
      endcase
    endfunction

    function int clamp(int y);
      int lo;
      lo = (min_off > 0) ? 0 : int'(min_off);
      if (y > 0) y = 0;
      if (y < lo) y = lo;
      return y;
    endfunction

    function void push(action_t a, kind_t k, logic [9:0] x, logic [9:0] y, int off);
      item_out_t r;
      r.action = a; r.event_kind = k; r.x_out = x; r.y_out = y;
      r.offset_out = off[15:0]; r.last = 0;
      pending_results.push_back(r);
    endfunction

    function void scroll_follow(logic [9:0] y, logic same);
      if (!same || !scroller) begin
        phase = PH_CONSUMED;
      end else begin
        scroll_pos = clamp(dn_off + (int'(y) - int'(dn_y)));
        push(ACT_SCROLL_SET, KIND_DOWN, 0, 0, scroll_pos);
      end
    endfunction

    // Note an accepted event and queue the results that it causes.
    function void note_event(item_in_t e);
      int queued, adx, ady, dx, dy, carry;
      logic [31:0] dt;
      phase_t ph;
      logic handled;
      queued = pending_results.size();
      case (mode_t'(e.mode))
        MODE_DOWN: begin
          armed = 0;
          if (e.unarmed_touch) begin
            phase = PH_IDLE;
          end else begin
            phase = PH_PENDING;
            dn_x = e.x_pos; dn_y = e.y_pos; dn_time = e.now_time;
            y_last = e.y_pos; y_prev = e.y_pos;
            t_last = e.now_time; t_prev = e.now_time;
            scroller = e.scrollable;
            dn_off = e.scrollable ? int'(e.current_offset) : 0;
            scroll_pos = dn_off;
            armed = lp_en && e.menu_on_top;
          end
          push(ACT_FORWARD, KIND_DOWN, e.x_pos, e.y_pos, 0);
        end
        MODE_MOVE: begin
          if (phase == PH_PENDING || phase == PH_DRAG) begin
            y_prev = y_last; t_prev = t_last;
            y_last = e.y_pos; t_last = e.now_time;
          end
          if (phase == PH_PENDING) begin
            adx = int'(e.x_pos) - int'(dn_x); if (adx < 0) adx = -adx;
            ady = int'(e.y_pos) - int'(dn_y); if (ady < 0) ady = -ady;
            if (adx >= int'(slop) || ady >= int'(slop)) armed = 0;
            if (scroller && ady >= int'(drag_thr)) begin
              armed = 0;
              phase = PH_DRAG;
              scroll_follow(e.y_pos, e.same_layer);
            end
          end else if (phase == PH_DRAG) begin
            scroll_follow(e.y_pos, e.same_layer);
          end
          if (fwd_moves) push(ACT_FORWARD, KIND_MOVE, e.x_pos, e.y_pos, 0);
        end
        MODE_UP: begin
          ph = phase;
          handled = 0;
          armed = 0;
          phase = PH_IDLE;
          if (ph == PH_DRAG) begin
            handled = 1;
            dt = t_last - t_prev;
            if (e.same_layer && dt != 0 && dt <= FLING_MAX_DT) begin
              dy = int'(y_last) - int'(y_prev);
              carry = dy * int'(FLING_SPAN_MS_DEF) / int'(dt);
              if (carry != 0) begin
                scroll_pos = clamp(scroll_pos + carry);
                push(ACT_SCROLL_ANIM, KIND_DOWN, 0, 0, scroll_pos);
              end
            end
          end else if (ph == PH_CONSUMED) begin
            handled = 1;
          end else if (ph == PH_PENDING &&
                       (e.now_time - dn_time) <= GESTURE_LIMIT_MS_DEF) begin
            dx = int'(e.x_pos) - int'(dn_x);
            adx = (dx < 0) ? -dx : dx;
            ady = int'(e.y_pos) - int'(dn_y); if (ady < 0) ady = -ady;
            if (adx < int'(slop) && ady < int'(slop)) begin
              if (e.menu_on_top) begin
                push(ACT_TAP, KIND_DOWN, e.x_pos, e.y_pos, 0);
                handled = 1;
              end
            end else if (adx >= int'(swipe_thr) && adx > ady && dx > 0 && e.link_up) begin
              push(ACT_BACK, KIND_DOWN, 0, 0, 0);
              handled = 1;
            end
          end
          if (!handled) push(ACT_FORWARD, KIND_UP, e.x_pos, e.y_pos, 0);
        end
        default: begin
          if (armed && (e.now_time - dn_time) >= {16'd0, hold_ms}) begin
            armed = 0;
            if (phase == PH_PENDING && e.menu_on_top) begin
              phase = PH_CONSUMED;
              push(ACT_LONG, KIND_DOWN, dn_x, dn_y, 0);
            end
          end
        end
      endcase
      if (pending_results.size() > queued)
        pending_results[pending_results.size() - 1].last = 1;
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(item_out_t got);
      item_out_t exp_r;
      if (pending_results.size() == 0) begin
        $error("unexpected result: action %0d", got.action);
        error_count++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.action !== exp_r.action) begin
        $error("action: expected %0d, got %0d", exp_r.action, got.action);
        error_count++;
      end
      if (got.event_kind !== exp_r.event_kind) begin
        $error("event_kind: expected %0d, got %0d", exp_r.event_kind, got.event_kind);
        error_count++;
      end
      if (got.x_out !== exp_r.x_out) begin
        $error("x_out: expected %0d, got %0d", exp_r.x_out, got.x_out);
        error_count++;
      end
      if (got.y_out !== exp_r.y_out) begin
        $error("y_out: expected %0d, got %0d", exp_r.y_out, got.y_out);
        error_count++;
      end
      if (got.offset_out !== exp_r.offset_out) begin
        $error("offset_out: expected %0d, got %0d", exp_r.offset_out, got.offset_out);
        error_count++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, got.last);
        error_count++;
      end
    endfunction
  endclass

  localparam int HOLD_OFF_CYCLES = 300;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tgc_stream_if #(.payload_t(item_in_t)) in_ch ();
  tgc_stream_if #(.payload_t(item_out_t)) out_ch ();

  touch_gesture_classifier_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gesture_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 0;
  logic hold_taken;
  int hold_left;
  logic [31:0] clock_ms = 0;
  logic [9:0] touch_x = 0, touch_y = 0;

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off when one is requested.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if (rst) begin
      out_ch.ready <= 0;
      hold_left <= 0;
      hold_taken <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_taken <= 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Run limit.
  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  // Send one event; the scoreboard notes it when it is accepted. Valid stays
  // high afterwards so that events can follow back to back.
  task automatic send_event(item_in_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_event(e);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.set_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic item_in_t make_event(mode_t m, logic [9:0] x, logic [9:0] y,
                                          logic [31:0] t);
    item_in_t e;
    e.mode = m; e.x_pos = x; e.y_pos = y; e.now_time = t;
    e.unarmed_touch = ($urandom_range(9) == 0);
    e.menu_on_top = 1'($urandom_range(1));
    e.scrollable = ($urandom_range(3) != 0);
    e.current_offset = 16'(-$signed(17'($urandom_range(32768))));
    if ($urandom_range(3) == 0) e.current_offset = 0;
    e.link_up = ($urandom_range(4) != 0);
    e.same_layer = ($urandom_range(9) != 0);
    return e;
  endfunction

  // One well-formed gesture: touchdown, moves and ticks, then liftoff.
  task automatic send_gesture();
    item_in_t e;
    int steps;
    touch_x = 10'($urandom); touch_y = 10'($urandom);
    e = make_event(MODE_DOWN, touch_x, touch_y, clock_ms);
    send_event(e);
    steps = $urandom_range(6);
    repeat (steps) begin
      clock_ms += ($urandom_range(3) == 0) ? $urandom_range(700) : $urandom_range(40);
      if ($urandom_range(3) == 0) begin
        send_event(make_event(MODE_TICK, 10'($urandom), 10'($urandom), clock_ms));
      end else begin
        touch_x = touch_x + 10'($signed($urandom_range(80)) - 30);
        touch_y = touch_y + 10'($signed($urandom_range(120)) - 60);
        send_event(make_event(MODE_MOVE, touch_x, touch_y, clock_ms));
      end
    end
    clock_ms += $urandom_range(60);
    if ($urandom_range(1)) touch_x = touch_x + 10'($urandom_range(60));
    send_event(make_event(MODE_UP, touch_x, touch_y, clock_ms));
  endtask

  task automatic random_phase(int gestures);
    item_in_t e;
    repeat (gestures) begin
      if ($urandom_range(9) == 0) begin
        // Noise: a fully random event.
        e = make_event(mode_t'($urandom_range(3)), 10'($urandom), 10'($urandom),
                       $urandom);
        e.current_offset = 16'($urandom);
        if (e.current_offset > 0) e.current_offset = -e.current_offset;
        if ($urandom_range(1)) clock_ms = e.now_time;
        send_event(e);
      end else begin
        send_gesture();
      end
    end
  endtask

  // Main stimulus.
  initial begin
    item_in_t e;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed corner cases at default settings.
    e = make_event(MODE_DOWN, 10'd0, 10'd0, 32'hFFFF_FF00);
    e.unarmed_touch = 0; e.menu_on_top = 1; e.scrollable = 0;
    send_event(e);
    e.mode = MODE_TICK; e.now_time = 32'h0000_0200; send_event(e);
    e.mode = MODE_UP; send_event(e);
    e = make_event(MODE_DOWN, 10'd1023, 10'd1023, 0);
    e.unarmed_touch = 1; send_event(e);
    e = make_event(MODE_DOWN, 10'd100, 10'd500, 100);
    e.unarmed_touch = 0; e.menu_on_top = 1; send_event(e);
    e.mode = MODE_UP; e.x_pos = 10'd105; e.now_time = 150; send_event(e);
    e = make_event(MODE_DOWN, 10'd100, 10'd500, 200);
    e.unarmed_touch = 0; e.link_up = 1; send_event(e);
    e.mode = MODE_UP; e.x_pos = 10'd200; e.now_time = 300; send_event(e);
    e = make_event(MODE_DOWN, 10'd100, 10'd500, 400);
    e.unarmed_touch = 0; send_event(e);
    e.mode = MODE_UP; e.now_time = 3000; send_event(e);
    e = make_event(MODE_DOWN, 10'd300, 10'd300, 5000);
    e.unarmed_touch = 0; e.scrollable = 1; e.current_offset = -16'sd32768;
    e.same_layer = 1; send_event(e);
    e.mode = MODE_MOVE; e.y_pos = 10'd600; e.now_time = 5010; send_event(e);
    e.y_pos = 10'd900; e.now_time = 5020; send_event(e);
    e.mode = MODE_UP; send_event(e);
    e.mode = MODE_DOWN; e.current_offset = 0; e.now_time = 6000; send_event(e);
    e.mode = MODE_MOVE; e.y_pos = 10'd1023; e.same_layer = 0; send_event(e);
    e.mode = MODE_UP; send_event(e);
    drain();

    // Sender idles, receiver mostly stalls.
    write_reg(REG_FORWARD_MOVES, 1);
    write_reg(REG_LP_ENABLE, 1);
    write_reg(REG_MIN_OFFSET, 32'hFFFF_8000);
    write_reg(REG_TAP_SLOP, 255);
    write_reg(REG_SWIPE_MIN, 1023);
    write_reg(REG_DRAG_START, 1);
    write_reg(REG_LP_MS, 1);
    send_idle_pct = 7; recv_idle_pct = 83;
    random_phase(80);
    drain();

    // Receiver idles, sender mostly stalls.
    write_reg(REG_FORWARD_MOVES, 0);
    write_reg(REG_LP_ENABLE, 0);
    write_reg(REG_MIN_OFFSET, 32'hFFFF_FC00);
    write_reg(REG_TAP_SLOP, 1);
    write_reg(REG_SWIPE_MIN, 1);
    write_reg(REG_DRAG_START, 255);
    write_reg(REG_LP_MS, 65535);
    send_idle_pct = 83; recv_idle_pct = 7;
    random_phase(80);
    drain();

    // No idling; a long receiver hold-off fills the block.
    write_reg(REG_FORWARD_MOVES, 1);
    write_reg(REG_LP_ENABLE, 1);
    write_reg(REG_MIN_OFFSET, 32'hFFFF_F000);
    write_reg(REG_TAP_SLOP, 10);
    write_reg(REG_SWIPE_MIN, 30);
    write_reg(REG_DRAG_START, 8);
    write_reg(REG_LP_MS, 300);
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_req = 1;
    random_phase(160);
    // The sender pauses here until every expected result has come.
    drain();
    random_phase(50);

    in_ch.valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
